>>> hdl/rgc_pkg.sv
// rgc_pkg: shared types, codes and character classes for the readability
// grade counter. No dependencies; used by rgc_ctrl, rgc_dp and the top level.
`default_nettype none

package rgc_pkg;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int GAIN_W     = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WGAIN  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SGAIN  = 2'd2;

    // reset values of the grade coefficients (Q8)
    localparam logic signed [GAIN_W-1:0] OFFSET_RST = -16'sd3991;
    localparam logic [GAIN_W-1:0]        WGAIN_RST  = 16'd100;
    localparam logic [GAIN_W-1:0]        SGAIN_RST  = 16'd3021;

    // result widths
    localparam int OUT_CNT_W = 24;
    localparam int GRADE_W   = 32;
    localparam logic signed [GRADE_W-1:0] GRADE_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [GRADE_W-1:0] GRADE_MIN = 32'sh8000_0000;

    // per-word syllable counter
    localparam int SYL_W = 8;
    localparam logic [SYL_W-1:0] SYL_MAX = 8'hFF;

    // ASCII codes
    localparam logic [7:0] CH_UP_A    = 8'h41;
    localparam logic [7:0] CH_UP_Z    = 8'h5A;
    localparam logic [7:0] CH_LO_A    = 8'h61;
    localparam logic [7:0] CH_LO_E    = 8'h65;
    localparam logic [7:0] CH_LO_I    = 8'h69;
    localparam logic [7:0] CH_LO_O    = 8'h6F;
    localparam logic [7:0] CH_LO_U    = 8'h75;
    localparam logic [7:0] CH_LO_Y    = 8'h79;
    localparam logic [7:0] CH_LO_Z    = 8'h7A;
    localparam logic [7:0] CH_DIG_0   = 8'h30;
    localparam logic [7:0] CH_DIG_9   = 8'h39;
    localparam logic [7:0] CH_USCORE  = 8'h5F;
    localparam logic [7:0] CH_APOS    = 8'h27;
    localparam logic [7:0] CH_PERIOD  = 8'h2E;
    localparam logic [7:0] CH_BANG    = 8'h21;
    localparam logic [7:0] CH_QUEST   = 8'h3F;
    localparam logic [7:0] CASE_BIT   = 8'h20;

    // controller -> datapath
    typedef struct packed {
        logic scan;     // text byte transaction accepted
        logic mul;      // gain x count into product register
        logic sel;      // 0: words per sentence term, 1: syllables per word term
        logic keep_t1;  // save first quotient
        logic load;     // load divider from product
        logic step;     // one divider iteration
        logic sum;      // form grade sum
        logic fin;      // load result registers, clear counters
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic grade_ok;
        logic div_last;
    } t_sts;

    function automatic logic f_is_letter(input logic [7:0] c);
        return (c >= CH_UP_A && c <= CH_UP_Z) || (c >= CH_LO_A && c <= CH_LO_Z);
    endfunction

    function automatic logic f_is_word_char(input logic [7:0] c);
        return f_is_letter(c) || (c >= CH_DIG_0 && c <= CH_DIG_9) ||
               c == CH_USCORE || c == CH_APOS;
    endfunction

    function automatic logic f_is_vowel(input logic [7:0] c);
        logic [7:0] l;
        l = c | CASE_BIT;
        return f_is_letter(c) && (l == CH_LO_A || l == CH_LO_E || l == CH_LO_I ||
                                  l == CH_LO_O || l == CH_LO_U || l == CH_LO_Y);
    endfunction

    function automatic logic f_is_e(input logic [7:0] c);
        return (c | CASE_BIT) == CH_LO_E;
    endfunction

    function automatic logic f_is_sentence_end(input logic [7:0] c);
        return c == CH_PERIOD || c == CH_BANG || c == CH_QUEST;
    endfunction

endpackage

`default_nettype wire

>>> hdl/rgc_ctrl.sv
// rgc_ctrl: sequencing FSM for the readability grade counter.
// Drives handshakes and datapath commands; depends on rgc_pkg.
`default_nettype none

module rgc_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    input  wire logic          i_in_eot,
    input  wire logic          i_out_stall,
    input  wire rgc_pkg::t_sts i_sts,
    output logic               o_in_stall,
    output logic               o_out_valid,
    output rgc_pkg::t_cmd      o_cmd
);

    typedef enum logic [2:0] {
        S_SCAN,
        S_MUL,
        S_LOAD,
        S_DIV,
        S_SUM,
        S_FIN
    } t_state;

    t_state r_state;
    logic   r_stall;
    logic   r_out_valid;
    logic   r_sel;
    logic   out_free;
    logic   n_out_valid;

    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        o_cmd         = '0;
        o_cmd.scan    = (r_state == S_SCAN) && i_in_valid && !r_stall;
        o_cmd.mul     = (r_state == S_MUL);
        o_cmd.sel     = r_sel;
        o_cmd.keep_t1 = (r_state == S_MUL) && r_sel;
        o_cmd.load    = (r_state == S_LOAD);
        o_cmd.step    = (r_state == S_DIV);
        o_cmd.sum     = (r_state == S_SUM);
        o_cmd.fin     = (r_state == S_FIN) && out_free;
    end

    // new result loads, or the held one stays until taken
    assign n_out_valid = o_cmd.fin || (r_out_valid && i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_SCAN;
            r_stall     <= 1'b0;
            r_out_valid <= 1'b0;
            r_sel       <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            case (r_state)
                S_SCAN: begin
                    if (o_cmd.scan && i_in_eot) begin
                        r_state <= S_MUL;
                        r_stall <= 1'b1;
                        r_sel   <= 1'b0;
                    end
                end
                S_MUL: begin
                    r_state <= i_sts.grade_ok ? S_LOAD : S_SUM;
                end
                S_LOAD: begin
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (i_sts.div_last) begin
                        if (!r_sel) begin
                            r_sel   <= 1'b1;
                            r_state <= S_MUL;
                        end else begin
                            r_state <= S_SUM;
                        end
                    end
                end
                S_SUM: begin
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    if (out_free) begin
                        r_stall <= 1'b0;
                        r_state <= S_SCAN;
                    end
                end
                default: begin
                    r_state <= S_SCAN;
                    r_stall <= 1'b0;
                end
            endcase
        end
    end

    assign o_in_stall  = r_stall;
    assign o_out_valid = r_out_valid;

`ifndef NO_ASSERTIONS
    // input is open exactly while scanning
    a_scan_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> !r_stall)
        else $error("stall high while scanning");

    // last byte closes the input and starts the grade pass
    a_eot_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.scan && i_in_eot) |=> (r_state == S_MUL && r_stall && !r_sel))
        else $error("end of text did not start grade pass");

    // a result only appears from the final state
    a_result_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_FIN))
        else $error("result valid without finish");

    // at most one datapath action per cycle
    a_cmd_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_cmd.scan, o_cmd.mul, o_cmd.load, o_cmd.step, o_cmd.sum, o_cmd.fin}))
        else $error("overlapping datapath commands");
`endif

endmodule

`default_nettype wire

>>> hdl/rgc_dp.sv
// rgc_dp: datapath of the readability grade counter: text scanner and
// counters, config registers, gain multiplier, shared restoring divider,
// grade sum and result registers. Depends on rgc_pkg.
`default_nettype none

module rgc_dp #(
    parameter int COUNT_BITS = 24
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire rgc_pkg::t_cmd                     i_cmd,
    output rgc_pkg::t_sts                          o_sts,
    input  wire logic [7:0]                        i_text_byte,
    input  wire logic                              i_end_of_text,
    input  wire logic                              i_cfg_we,
    input  wire logic [rgc_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire logic [rgc_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    output logic [rgc_pkg::OUT_CNT_W-1:0]          o_words_total,
    output logic [rgc_pkg::OUT_CNT_W-1:0]          o_syllables_total,
    output logic [rgc_pkg::OUT_CNT_W-1:0]          o_sentences_total,
    output logic                                   o_grade_valid,
    output logic signed [rgc_pkg::GRADE_W-1:0]     o_grade_q8,
    output logic                                   o_grade_saturated
);

    localparam int CB  = COUNT_BITS;
    localparam int GW_ = rgc_pkg::GAIN_W;
    localparam int PW  = CB + GW_;          // product
    localparam int NW  = PW + 2;            // dividend 2*g*n + d, also quotient
    localparam int DW  = CB + 2;            // divisor 2*d and remainder
    localparam int CW  = $clog2(NW);
    localparam int SW  = (NW + 2 > 34) ? NW + 2 : 34;   // grade sum
    localparam int OW  = rgc_pkg::OUT_CNT_W;
    localparam int YW  = rgc_pkg::SYL_W;

    // config registers
    logic signed [GW_-1:0] r_offset;
    logic [GW_-1:0]        r_wgain;
    logic [GW_-1:0]        r_sgain;

    // scanner state
    logic          r_inside;
    logic          r_word;
    logic          r_prev;
    logic          r_pend;
    logic [YW-1:0] r_syl;
    logic [CB-1:0] r_wcnt;
    logic [CB-1:0] r_ycnt;
    logic [CB-1:0] r_scnt;
    logic          r_clip;

    // arithmetic
    logic [PW-1:0]        r_prod;
    logic [CB-1:0]        r_den;
    logic [NW-1:0]        r_num;
    logic [DW-1:0]        r_dvs;
    logic [DW-1:0]        r_rem;
    logic [CW-1:0]        r_cnt;
    logic [NW-1:0]        r_t1;
    logic signed [SW-1:0] r_sum;
    logic                 r_sum_ok;

    // result registers
    logic [OW-1:0]                        r_out_w;
    logic [OW-1:0]                        r_out_y;
    logic [OW-1:0]                        r_out_s;
    logic                                 r_out_ok;
    logic signed [rgc_pkg::GRADE_W-1:0]   r_out_g;
    logic                                 r_out_sat;

    // scanner combinational
    logic          wc, letter, vowel, is_e, start;
    logic          b_word, b_prev, b_pend;
    logic [YW-1:0] b_syl;
    logic          n_inside, n_word, n_prev, n_pend;
    logic [YW-1:0] n_syl;
    logic          bump, syl_clip;
    logic          close_tok, word_close, sent_add;
    logic [YW-1:0] syl_eff;
    logic [CB:0]   ysum;
    logic [CB-1:0] cmax;
    logic          scan_clip;

    assign cmax   = {CB{1'b1}};
    assign wc     = rgc_pkg::f_is_word_char(i_text_byte);
    assign letter = rgc_pkg::f_is_letter(i_text_byte);
    assign vowel  = rgc_pkg::f_is_vowel(i_text_byte);
    assign is_e   = rgc_pkg::f_is_e(i_text_byte);
    assign start  = wc && !r_inside;

    always_comb begin
        b_word   = start ? letter : r_word;
        b_prev   = start ? 1'b0 : r_prev;
        b_pend   = start ? 1'b0 : r_pend;
        b_syl    = start ? '0 : r_syl;
        n_inside = wc ? 1'b1 : r_inside;
        n_word   = wc ? b_word : r_word;
        n_prev   = b_prev;
        n_pend   = b_pend;
        n_syl    = b_syl;
        bump     = 1'b0;
        syl_clip = 1'b0;
        if (wc && b_word) begin
            // a vowel opening a group counts, a lone 'e' waits to see if it ends the word
            bump   = b_pend || (vowel && !b_prev && !is_e);
            n_pend = vowel && !b_prev && is_e;
            n_prev = vowel;
            if (bump) begin
                if (b_syl == rgc_pkg::SYL_MAX) begin
                    syl_clip = 1'b1;
                end else begin
                    n_syl = b_syl + 1'b1;
                end
            end
        end
    end

    assign close_tok  = !wc || i_end_of_text;
    assign word_close = close_tok && n_inside && n_word;
    assign sent_add   = !wc && rgc_pkg::f_is_sentence_end(i_text_byte);
    assign syl_eff    = (n_syl == '0) ? YW'(1) : n_syl;
    assign ysum       = {1'b0, r_ycnt} + {{(CB + 1 - YW){1'b0}}, syl_eff};

    // any count that would pass its maximum on this byte
    assign scan_clip  = syl_clip ||
                        (word_close && ((r_wcnt == cmax) || (ysum > {1'b0, cmax}))) ||
                        (sent_add && (r_scnt == cmax));

    // multiplier operands
    logic [GW_-1:0] mul_a;
    logic [CB-1:0]  mul_b;
    logic [CB-1:0]  den_c;
    logic [PW-1:0]  prod_c;

    assign mul_a  = i_cmd.sel ? r_sgain : r_wgain;
    assign mul_b  = i_cmd.sel ? r_ycnt : r_wcnt;
    assign den_c  = i_cmd.sel ? r_wcnt : r_scnt;
    assign prod_c = {{CB{1'b0}}, mul_a} * {{GW_{1'b0}}, mul_b};

    // divider step
    logic [DW-1:0] rem_sh;
    logic          q_bit;

    assign rem_sh = {r_rem[DW-2:0], r_num[NW-1]};
    assign q_bit  = rem_sh >= r_dvs;

    // grade saturation
    logic signed [SW-1:0] c_gmax, c_gmin;
    logic                 sat_hi, sat_lo;

    assign c_gmax = SW'(rgc_pkg::GRADE_MAX);
    assign c_gmin = SW'(rgc_pkg::GRADE_MIN);
    assign sat_hi = r_sum > c_gmax;
    assign sat_lo = r_sum < c_gmin;

    // counters to result width
    logic [OW+CB-1:0] ext_w, ext_y, ext_s;

    assign ext_w = {{OW{1'b0}}, r_wcnt};
    assign ext_y = {{OW{1'b0}}, r_ycnt};
    assign ext_s = {{OW{1'b0}}, r_scnt};

    assign o_sts.grade_ok = (r_wcnt != '0) && (r_scnt != '0);
    assign o_sts.div_last = (r_cnt == CW'(NW - 1));

    // config
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset <= rgc_pkg::OFFSET_RST;
            r_wgain  <= rgc_pkg::WGAIN_RST;
            r_sgain  <= rgc_pkg::SGAIN_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                rgc_pkg::CFG_OFFSET: r_offset <= $signed(i_cfg_data);
                rgc_pkg::CFG_WGAIN:  r_wgain  <= i_cfg_data;
                rgc_pkg::CFG_SGAIN:  r_sgain  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // scanner and counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inside <= 1'b0;
            r_word   <= 1'b0;
            r_prev   <= 1'b0;
            r_pend   <= 1'b0;
            r_syl    <= '0;
            r_wcnt   <= '0;
            r_ycnt   <= '0;
            r_scnt   <= '0;
            r_clip   <= 1'b0;
        end else if (i_cmd.fin) begin
            r_wcnt <= '0;
            r_ycnt <= '0;
            r_scnt <= '0;
            r_clip <= 1'b0;
        end else if (i_cmd.scan) begin
            if (close_tok) begin
                r_inside <= 1'b0;
                r_word   <= 1'b0;
                r_prev   <= 1'b0;
                r_pend   <= 1'b0;
                r_syl    <= '0;
            end else begin
                r_inside <= n_inside;
                r_word   <= n_word;
                r_prev   <= n_prev;
                r_pend   <= n_pend;
                r_syl    <= n_syl;
            end
            if (scan_clip) begin
                r_clip <= 1'b1;
            end
            if (word_close) begin
                if (r_wcnt != cmax) begin
                    r_wcnt <= r_wcnt + 1'b1;
                end
                if (ysum > {1'b0, cmax}) begin
                    r_ycnt <= cmax;
                end else begin
                    r_ycnt <= ysum[CB-1:0];
                end
            end
            if (sent_add) begin
                if (r_scnt != cmax) begin
                    r_scnt <= r_scnt + 1'b1;
                end
            end
        end
    end

    // multiply, divide, sum and result registers: payload only
    always_ff @(posedge i_clk) begin
        if (i_cmd.mul) begin
            r_prod <= prod_c;
            r_den  <= den_c;
        end
        if (i_cmd.keep_t1) begin
            r_t1 <= r_num;
        end
        if (i_cmd.load) begin
            // round to nearest: (2*g*n + d) / (2*d)
            r_num <= {1'b0, r_prod, 1'b0} + {{(NW - CB){1'b0}}, r_den};
            r_dvs <= {1'b0, r_den, 1'b0};
            r_rem <= '0;
            r_cnt <= '0;
        end else if (i_cmd.step) begin
            r_rem <= q_bit ? (rem_sh - r_dvs) : rem_sh;
            r_num <= {r_num[NW-2:0], q_bit};
            r_cnt <= r_cnt + 1'b1;
        end
        if (i_cmd.sum) begin
            r_sum_ok <= o_sts.grade_ok;
            if (o_sts.grade_ok) begin
                r_sum <= SW'(r_offset) + $signed({{(SW - NW){1'b0}}, r_t1})
                         + $signed({{(SW - NW){1'b0}}, r_num});
            end else begin
                r_sum <= '0;
            end
        end
        if (i_cmd.fin) begin
            r_out_w   <= ext_w[OW-1:0];
            r_out_y   <= ext_y[OW-1:0];
            r_out_s   <= ext_s[OW-1:0];
            r_out_ok  <= r_sum_ok;
            r_out_g   <= sat_hi ? rgc_pkg::GRADE_MAX :
                         sat_lo ? rgc_pkg::GRADE_MIN : r_sum[rgc_pkg::GRADE_W-1:0];
            r_out_sat <= sat_hi || sat_lo || r_clip;
        end
    end

    assign o_words_total     = r_out_w;
    assign o_syllables_total = r_out_y;
    assign o_sentences_total = r_out_s;
    assign o_grade_valid     = r_out_ok;
    assign o_grade_q8        = r_out_g;
    assign o_grade_saturated = r_out_sat;

endmodule

`default_nettype wire

>>> hdl/readability_grade_counter_unit.sv
// readability_grade_counter_unit: top level, joins rgc_ctrl and rgc_dp.
// Depends on rgc_pkg, rgc_ctrl, rgc_dp.
//
// Usage:
//   Text channel (i_in_valid / o_in_stall): one ASCII byte per transaction,
//   i_end_of_text high on the last byte. While scanning, a byte is taken
//   every cycle. The last byte closes the text and starts the grade pass.
//   Result channel (o_out_valid / i_out_stall): one transaction per text with
//   word, syllable and sentence totals, grade valid flag, Q8 grade and the
//   saturation flag. The result sits in an output register until taken.
//   The grade pass runs two divisions on one shared restoring divider,
//   one quotient bit per cycle over COUNT_BITS+18 bits, and skips them
//   when the grade is not valid. o_in_stall is high during the pass, so
//   the next text starts after the result is loaded.
//   If the receiver still stalls an older result, the pass waits in its final
//   state with the input closed.
//   Reset (i_rst_n low, synchronous) clears all counters, returns the
//   coefficient registers to their defaults and drops o_out_valid.
//   Config (i_cfg_we / i_cfg_idx / i_cfg_data): 0 offset, 1 words per
//   sentence gain, 2 syllables per word gain; the user must see that they are
//   written only while idle, as the block itself does not enforce it.
`default_nettype none

module readability_grade_counter_unit #(
    parameter int COUNT_BITS = 24
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // text channel
    input  wire logic                              i_in_valid,
    output logic                                   o_in_stall,
    input  wire logic [7:0]                        i_text_byte,
    input  wire logic                              i_end_of_text,
    // result channel
    output logic                                   o_out_valid,
    input  wire logic                              i_out_stall,
    output logic [rgc_pkg::OUT_CNT_W-1:0]          o_words_total,
    output logic [rgc_pkg::OUT_CNT_W-1:0]          o_syllables_total,
    output logic [rgc_pkg::OUT_CNT_W-1:0]          o_sentences_total,
    output logic                                   o_grade_valid,
    output logic signed [rgc_pkg::GRADE_W-1:0]     o_grade_q8,
    output logic                                   o_grade_saturated,
    // configuration
    input  wire logic                              i_cfg_we,
    input  wire logic [rgc_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire logic [rgc_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    rgc_pkg::t_cmd cmd;   // sequencer commands
    rgc_pkg::t_sts sts;   // datapath status

    rgc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_eot    (i_end_of_text),
        .i_out_stall (i_out_stall),
        .i_sts       (sts),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_cmd       (cmd)
    );

    // counters, coefficients, multiplier, divider and result registers
    rgc_dp #(
        .COUNT_BITS (COUNT_BITS)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_sts             (sts),
        .i_text_byte       (i_text_byte),
        .i_end_of_text     (i_end_of_text),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_idx         (i_cfg_idx),
        .i_cfg_data        (i_cfg_data),
        .o_words_total     (o_words_total),
        .o_syllables_total (o_syllables_total),
        .o_sentences_total (o_sentences_total),
        .o_grade_valid     (o_grade_valid),
        .o_grade_q8        (o_grade_q8),
        .o_grade_saturated (o_grade_saturated)
    );

endmodule

`default_nettype wire
